>>> hdl/tihb_pkg.sv
// ----------------------------------------------------------------------------
// TCP/IPv4 header builder package
// Shared widths, protocol constants and the packet job record.
// ----------------------------------------------------------------------------
package tihb_pkg;

    localparam int WORD_W          = 16;
    localparam int LEN_W           = 11;
    // Payload word sum: at most 1024 words of 16 bits.
    localparam int ACC_W           = WORD_W + LEN_W - 1;
    localparam int DEF_MAX_PAYLOAD = 2008;
    localparam logic [7:0] DEF_TTL = 8'hFF;
    localparam int Q_DEPTH         = 2;
    localparam int N_WORDS         = 20;
    localparam int IDX_W           = $clog2(N_WORDS);

    localparam logic [WORD_W-1:0] IP_VER_IHL = 16'h4500;
    localparam logic [7:0]        PROTO_TCP  = 8'd6;
    localparam int                HDR_BYTES  = 20;
    localparam logic [3:0]        TCP_OFFSET = 4'd5;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_DATA  = 1'b1
    } t_func;

    typedef struct packed {
        logic [31:0]       src_addr;
        logic [31:0]       dst_addr;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic [7:0]        tcp_flags;
        logic [31:0]       seq_num;
        logic [31:0]       ack_num;
        logic [15:0]       window;
        logic [15:0]       ident;
        logic [LEN_W-1:0]  len;
        logic [ACC_W-1:0]  pay_sum;
    } t_job;

endpackage

>>> hdl/tcp_ipv4_header_builder_top.sv
// Jobs pass from the queue through the checksum stages and the emitter to the output register.
// One request per cycle unless o_stall; 20 header words per packet, one per cycle unless i_stall.
// The output port sets the packet rate; a 2-entry job queue lets the front keep summing payload.
// Reset: synchronous, active low; the block comes up idle with the TTL register at 255.
// ----------------------------------------------------------------------------
// TCP/IPv4 header builder
// Builds IPv4 and TCP headers with checksums over a streamed payload.
// ----------------------------------------------------------------------------
module tcp_ipv4_header_builder_top #(
    parameter int MAX_PAYLOAD_BYTES = tihb_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [31:0]                   i_src_addr,
    input  logic [31:0]                   i_dst_addr,
    input  logic [15:0]                   i_src_port,
    input  logic [15:0]                   i_dst_port,
    input  logic [7:0]                    i_tcp_flags,
    input  logic [31:0]                   i_seq_num,
    input  logic [31:0]                   i_ack_num,
    input  logic [15:0]                   i_window,
    input  logic [15:0]                   i_ident,
    input  logic [tihb_pkg::LEN_W-1:0]    i_payload_len,
    input  logic [15:0]                   i_data_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tihb_pkg::WORD_W-1:0]   o_header_word,
    output logic                          o_last_of_run
);
    import tihb_pkg::*;

    logic [7:0] r_ttl;
    logic       w_push;
    t_job       w_push_job;
    logic       w_q_full;
    logic       w_q_pop;
    logic       w_q_valid;
    t_job       w_q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= DEF_TTL;
        end else if (i_cfg_we) begin
            r_ttl <= i_cfg_data;
        end
    end

    tihb_front #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_src_addr    (i_src_addr),
        .i_dst_addr    (i_dst_addr),
        .i_src_port    (i_src_port),
        .i_dst_port    (i_dst_port),
        .i_tcp_flags   (i_tcp_flags),
        .i_seq_num     (i_seq_num),
        .i_ack_num     (i_ack_num),
        .i_window      (i_window),
        .i_ident       (i_ident),
        .i_payload_len (i_payload_len),
        .i_data_word   (i_data_word),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_push_job    (w_push_job)
    );

    tihb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_job   (w_push_job),
        .o_full       (w_q_full),
        .i_pop        (w_q_pop),
        .o_head_valid (w_q_valid),
        .o_head_job   (w_q_job)
    );

    tihb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_job       (w_q_job),
        .o_q_pop       (w_q_pop),
        .i_ttl         (r_ttl),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_header_word (o_header_word),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> hdl/tihb_front.sv
// ----------------------------------------------------------------------------
// TCP/IPv4 header builder front end
// Takes start and payload requests, latches header fields, sums payload words
// and hands a finished packet job to the queue.
// ----------------------------------------------------------------------------
module tihb_front #(
    parameter int MAX_PAYLOAD_BYTES = tihb_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [31:0]                   i_src_addr,
    input  logic [31:0]                   i_dst_addr,
    input  logic [15:0]                   i_src_port,
    input  logic [15:0]                   i_dst_port,
    input  logic [7:0]                    i_tcp_flags,
    input  logic [31:0]                   i_seq_num,
    input  logic [31:0]                   i_ack_num,
    input  logic [15:0]                   i_window,
    input  logic [15:0]                   i_ident,
    input  logic [tihb_pkg::LEN_W-1:0]    i_payload_len,
    input  logic [15:0]                   i_data_word,
    input  logic                          i_q_full,
    output logic                          o_push,
    output tihb_pkg::t_job                o_push_job
);
    import tihb_pkg::*;

    t_job              r_hdr;
    logic [LEN_W-1:0]  r_rem;
    logic              r_in_packet;

    logic              w_accept;
    logic              w_start;
    logic              w_data;
    logic [LEN_W-1:0]  w_len;
    logic              w_two;
    logic [WORD_W-1:0] w_add;
    logic [ACC_W-1:0]  w_sum_new;
    logic [LEN_W-1:0]  w_rem_new;
    t_job              w_start_job;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !o_stall;
    assign w_start  = w_accept && (t_func'(i_func) == FUNC_START);
    assign w_data   = w_accept && (t_func'(i_func) == FUNC_DATA) && r_in_packet;

    assign w_len = (32'(i_payload_len) > 32'(MAX_PAYLOAD_BYTES))
                 ? LEN_W'(MAX_PAYLOAD_BYTES) : i_payload_len;

    // An odd final byte is padded with a zero low byte.
    assign w_two     = (r_rem >= LEN_W'(2));
    assign w_add     = w_two ? i_data_word : {i_data_word[15:8], 8'h00};
    assign w_sum_new = r_hdr.pay_sum + ACC_W'(w_add);
    assign w_rem_new = w_two ? (r_rem - LEN_W'(2)) : '0;

    always_comb begin
        w_start_job.src_addr  = i_src_addr;
        w_start_job.dst_addr  = i_dst_addr;
        w_start_job.src_port  = i_src_port;
        w_start_job.dst_port  = i_dst_port;
        w_start_job.tcp_flags = i_tcp_flags;
        w_start_job.seq_num   = i_seq_num;
        w_start_job.ack_num   = i_ack_num;
        w_start_job.window    = i_window;
        w_start_job.ident     = i_ident;
        w_start_job.len       = w_len;
        w_start_job.pay_sum   = '0;
    end

    always_comb begin
        o_push_job = r_hdr;
        o_push     = 1'b0;
        if (w_start) begin
            o_push_job = w_start_job;
            o_push     = (w_len == '0);
        end else if (w_data) begin
            o_push_job.pay_sum = w_sum_new;
            o_push             = (w_rem_new == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_rem       <= '0;
        end else if (w_start) begin
            r_in_packet <= (w_len != '0);
            r_rem       <= w_len;
        end else if (w_data) begin
            r_rem <= w_rem_new;
            if (w_rem_new == '0) begin
                r_in_packet <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_hdr <= w_start_job;
        end else if (w_data) begin
            r_hdr.pay_sum <= w_sum_new;
        end
    end

endmodule

>>> hdl/tihb_queue.sv
// ----------------------------------------------------------------------------
// TCP/IPv4 header builder job queue
// Small register FIFO of packet jobs between the front end and the emitter.
// ----------------------------------------------------------------------------
module tihb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tihb_pkg::t_job  i_push_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output tihb_pkg::t_job  o_head_job
);
    import tihb_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_job              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full       = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("job queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("job queue count did not follow a write");
`endif

endmodule

>>> hdl/tihb_back.sv
// ----------------------------------------------------------------------------
// TCP/IPv4 header builder back end
// Three checksum stages fold the header and payload sums, then the emitter
// sends the twenty header words through a registered output.
// ----------------------------------------------------------------------------
module tihb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tihb_pkg::t_job                i_q_job,
    output logic                          o_q_pop,
    input  logic [7:0]                    i_ttl,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tihb_pkg::WORD_W-1:0]   o_header_word,
    output logic                          o_last_of_run
);
    import tihb_pkg::*;

    localparam int P1_W  = WORD_W + 2;
    localparam int TD_W  = ACC_W + 1;
    localparam int IP_W  = WORD_W + 3;
    localparam int TCP_W = ACC_W + 2;
    localparam int F_W   = WORD_W + 1;

    // Stage 1: partial sums
    logic              r_p1_v;
    t_job              r_p1_job;
    logic [7:0]        r_p1_ttl;
    logic [P1_W-1:0]   r_p1_addr;
    logic [P1_W-1:0]   r_p1_ip;
    logic [P1_W-1:0]   r_p1_tcp_b;
    logic [P1_W-1:0]   r_p1_tcp_c;
    logic [TD_W-1:0]   r_p1_tcp_d;
    // Stage 2: totals
    logic              r_p2_v;
    t_job              r_p2_job;
    logic [7:0]        r_p2_ttl;
    logic [IP_W-1:0]   r_p2_ip;
    logic [TCP_W-1:0]  r_p2_tcp;
    // Stage 3: first fold
    logic              r_p3_v;
    t_job              r_p3_job;
    logic [7:0]        r_p3_ttl;
    logic [F_W-1:0]    r_p3_ip;
    logic [F_W-1:0]    r_p3_tcp;
    // Emitter
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;
    t_job              r_e_job;
    logic [7:0]        r_e_ttl;
    logic [WORD_W-1:0] r_ip_ck;
    logic [WORD_W-1:0] r_tcp_ck;
    // Output register
    logic              r_o_v;
    logic [WORD_W-1:0] r_o_word;
    logic              r_o_last;

    logic              w_out_rdy;
    logic              w_emit_adv;
    logic              w_emit_last;
    logic              w_emit_rdy;
    logic              w_load_e;
    logic              w_p3_rdy;
    logic              w_p2_rdy;
    logic              w_p1_rdy;
    logic [WORD_W-1:0] w_word;
    logic [WORD_W-1:0] w_tot_len;

    assign w_out_rdy   = !r_o_v || !i_stall;
    assign w_emit_adv  = r_busy && w_out_rdy;
    assign w_emit_last = (r_idx == IDX_W'(N_WORDS - 1));
    assign w_emit_rdy  = !r_busy || (w_emit_adv && w_emit_last);
    assign w_load_e    = r_p3_v && w_emit_rdy;
    assign w_p3_rdy    = !r_p3_v || w_emit_rdy;
    assign w_p2_rdy    = !r_p2_v || w_p3_rdy;
    assign w_p1_rdy    = !r_p1_v || w_p2_rdy;
    assign o_q_pop     = i_q_valid && w_p1_rdy;

    assign w_tot_len = WORD_W'(2 * HDR_BYTES) + WORD_W'(i_q_job.len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            if (w_p1_rdy) r_p1_v <= i_q_valid;
            if (w_p2_rdy) r_p2_v <= r_p1_v;
            if (w_p3_rdy) r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p1_rdy) begin
            r_p1_job   <= i_q_job;
            r_p1_ttl   <= i_ttl;
            // The address words appear in both the IPv4 and the pseudo-header sums.
            r_p1_addr  <= P1_W'(i_q_job.src_addr[31:16]) + P1_W'(i_q_job.src_addr[15:0])
                        + P1_W'(i_q_job.dst_addr[31:16]) + P1_W'(i_q_job.dst_addr[15:0]);
            r_p1_ip    <= P1_W'(IP_VER_IHL) + P1_W'(w_tot_len) + P1_W'(i_q_job.ident)
                        + P1_W'({i_ttl, PROTO_TCP});
            r_p1_tcp_b <= P1_W'(i_q_job.src_port) + P1_W'(i_q_job.dst_port)
                        + P1_W'(i_q_job.seq_num[31:16]) + P1_W'(i_q_job.seq_num[15:0]);
            r_p1_tcp_c <= P1_W'(i_q_job.ack_num[31:16]) + P1_W'(i_q_job.ack_num[15:0])
                        + P1_W'({TCP_OFFSET, 4'b0000, i_q_job.tcp_flags})
                        + P1_W'(i_q_job.window);
            r_p1_tcp_d <= TD_W'(i_q_job.pay_sum) + TD_W'(PROTO_TCP) + TD_W'(HDR_BYTES)
                        + TD_W'(i_q_job.len);
        end
        if (w_p2_rdy) begin
            r_p2_job <= r_p1_job;
            r_p2_ttl <= r_p1_ttl;
            r_p2_ip  <= IP_W'(r_p1_addr) + IP_W'(r_p1_ip);
            r_p2_tcp <= TCP_W'(r_p1_addr) + TCP_W'(r_p1_tcp_b) + TCP_W'(r_p1_tcp_c)
                      + TCP_W'(r_p1_tcp_d);
        end
        if (w_p3_rdy) begin
            r_p3_job <= r_p2_job;
            r_p3_ttl <= r_p2_ttl;
            r_p3_ip  <= F_W'(r_p2_ip[WORD_W-1:0]) + F_W'(r_p2_ip[IP_W-1:WORD_W]);
            r_p3_tcp <= F_W'(r_p2_tcp[WORD_W-1:0]) + F_W'(r_p2_tcp[TCP_W-1:WORD_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load_e) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_emit_adv) begin
            if (w_emit_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // The second fold cannot carry again, so one end-around add finishes it.
    always_ff @(posedge i_clk) begin
        if (w_load_e) begin
            r_e_job  <= r_p3_job;
            r_e_ttl  <= r_p3_ttl;
            r_ip_ck  <= ~(r_p3_ip[WORD_W-1:0] + WORD_W'(r_p3_ip[WORD_W]));
            r_tcp_ck <= ~(r_p3_tcp[WORD_W-1:0] + WORD_W'(r_p3_tcp[WORD_W]));
        end
    end

    always_comb begin
        unique case (r_idx)
            5'd0:    w_word = IP_VER_IHL;
            5'd1:    w_word = WORD_W'(2 * HDR_BYTES) + WORD_W'(r_e_job.len);
            5'd2:    w_word = r_e_job.ident;
            5'd3:    w_word = '0;
            5'd4:    w_word = {r_e_ttl, PROTO_TCP};
            5'd5:    w_word = r_ip_ck;
            5'd6:    w_word = r_e_job.src_addr[31:16];
            5'd7:    w_word = r_e_job.src_addr[15:0];
            5'd8:    w_word = r_e_job.dst_addr[31:16];
            5'd9:    w_word = r_e_job.dst_addr[15:0];
            5'd10:   w_word = r_e_job.src_port;
            5'd11:   w_word = r_e_job.dst_port;
            5'd12:   w_word = r_e_job.seq_num[31:16];
            5'd13:   w_word = r_e_job.seq_num[15:0];
            5'd14:   w_word = r_e_job.ack_num[31:16];
            5'd15:   w_word = r_e_job.ack_num[15:0];
            5'd16:   w_word = {TCP_OFFSET, 4'b0000, r_e_job.tcp_flags};
            5'd17:   w_word = r_e_job.window;
            5'd18:   w_word = r_tcp_ck;
            default: w_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_out_rdy) begin
            r_o_v <= w_emit_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_o_word <= w_word;
            r_o_last <= w_emit_last;
        end
    end

    assign o_valid       = r_o_v;
    assign o_header_word = r_o_word;
    assign o_last_of_run = r_o_last;

endmodule
